/* src/ned_pkg.sv */
// ----------------------------------------------------------------------------
// ned_pkg
// Shared types and constants of the normalized Euclidean distance block.
// ----------------------------------------------------------------------------
package ned_pkg;

  localparam int ELEMENT_BITS = 16;
  localparam int MAX_LENGTH   = 1024;

  localparam int LEN_W  = 11;                      // vector_length register
  localparam int MAG_W  = ELEMENT_BITS;            // |other - own|
  localparam int SQ_W   = 2 * MAG_W;               // one squared difference
  localparam int SUM_W  = 44;                      // running sum of squares
  localparam int MAXD_W = SQ_W + 10;               // span^2 * capped length
  localparam int BIND_W = 17;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [SUM_W-1:0]  SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [BIND_W-1:0] ONE_Q16     = BIND_W'(65536);
  localparam logic [LEN_W-1:0]  LEN_CAP     = LEN_W'(MAX_LENGTH);

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_LOWER  = 2'd0;
  localparam logic [1:0] REG_UPPER  = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;

  localparam logic signed [ELEMENT_BITS-1:0] LOWER_RESET  = ELEMENT_BITS'(0);
  localparam logic signed [ELEMENT_BITS-1:0] UPPER_RESET  = ELEMENT_BITS'(256);
  localparam logic [LEN_W-1:0]               LENGTH_RESET = LEN_W'(1);

  typedef struct packed {
    logic signed [ELEMENT_BITS-1:0] own_element;
    logic signed [ELEMENT_BITS-1:0] other_element;
    logic                           last;
  } in_t;

  typedef struct packed {
    logic [BIND_W-1:0] binding;
    logic              degenerate_range;
  } out_t;

  typedef struct packed {
    logic signed [ELEMENT_BITS-1:0] lower_bound;
    logic signed [ELEMENT_BITS-1:0] upper_bound;
    logic [LEN_W-1:0]               vector_length;
  } cfg_t;

  // Handshake between the queue and the back end
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } qout_t;

endpackage

/* src/normalized_euclidean_distance.sv */
// ----------------------------------------------------------------------------
// normalized_euclidean_distance
// Streams element pairs, accumulates squared differences and on the last
// pair emits sqrt(sum) / (span * sqrt(length)), clamped, in Q1.16.
//
//   channel  | signals                         | payload
//   ---------+---------------------------------+-------------------------
//   in       | in_valid_i / in_stall_o         | in_data_i  (ned_pkg::in_t)
//   out      | out_valid_o / out_stall_i       | out_data_o (ned_pkg::out_t)
//   config   | psel/penable/pwrite/paddr/...   | pwdata / prdata, 32 bits
//
// The front takes one element pair per cycle (multiply, then accumulate)
// unless a last pair is stalled. Each vector passes through the back end in
// 5 setup steps, 32 divide steps and 16 square-root steps (a clamped vector
// skips the last two), then the output register; a two-entry queue of sums
// lets the front run ahead by two vectors. Reset clears the sum, the queue
// and the registers to their defaults. in_stall_o rises only while a last pair waits for room in the queue.
// ----------------------------------------------------------------------------
module normalized_euclidean_distance (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ned_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ned_pkg::out_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ned_pkg::ADDR_W-1:0]  paddr,
  input  logic [ned_pkg::DATA_W-1:0]  pwdata,
  output logic [ned_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  ned_pkg::cfg_t             cfg_q;
  logic                      wr_en;
  logic                      push;
  logic [ned_pkg::SUM_W-1:0] push_sum;
  logic                      full;
  logic                      pop;
  ned_pkg::qout_t            head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower_bound   <= ned_pkg::LOWER_RESET;
      cfg_q.upper_bound   <= ned_pkg::UPPER_RESET;
      cfg_q.vector_length <= ned_pkg::LENGTH_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        ned_pkg::REG_LOWER:  cfg_q.lower_bound   <= pwdata[ned_pkg::ELEMENT_BITS-1:0];
        ned_pkg::REG_UPPER:  cfg_q.upper_bound   <= pwdata[ned_pkg::ELEMENT_BITS-1:0];
        ned_pkg::REG_LENGTH: cfg_q.vector_length <= pwdata[ned_pkg::LEN_W-1:0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ned_pkg::REG_LOWER:  prdata = ned_pkg::DATA_W'(cfg_q.lower_bound);
      ned_pkg::REG_UPPER:  prdata = ned_pkg::DATA_W'(cfg_q.upper_bound);
      ned_pkg::REG_LENGTH: prdata = ned_pkg::DATA_W'(cfg_q.vector_length);
      default:             prdata = '0;
    endcase
  end

  ned_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_sum_o (push_sum),
    .full_i     (full)
  );

  ned_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_sum_i (push_sum),
    .full_o     (full),
    .head_o     (head),
    .pop_i      (pop)
  );

  ned_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* src/ned_front.sv */
// ----------------------------------------------------------------------------
// ned_front
// Takes element pairs, squares the difference and accumulates the sum.
// On a last pair it pushes the finished sum into the queue and clears.
// ----------------------------------------------------------------------------
module ned_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  ned_pkg::in_t             in_data_i,
  output logic                     push_o,
  output logic [ned_pkg::SUM_W-1:0] push_sum_o,
  input  logic                     full_i
);

  logic                          sq_valid_q;
  logic                          sq_last_q;
  logic [ned_pkg::SQ_W-1:0]      sq_q, sq_d;
  logic [ned_pkg::SUM_W-1:0]     acc_q, acc_d;
  logic signed [ned_pkg::MAG_W:0] diff;
  logic [ned_pkg::MAG_W-1:0]     mag;
  logic [ned_pkg::SUM_W:0]       sum_ext;
  logic [ned_pkg::SUM_W-1:0]     sum_sat;
  logic                          advance;
  logic                          accept;

  always_comb begin
    diff = {in_data_i.other_element[ned_pkg::MAG_W-1], in_data_i.other_element}
         - {in_data_i.own_element[ned_pkg::MAG_W-1], in_data_i.own_element};
    mag  = diff[ned_pkg::MAG_W] ? ned_pkg::MAG_W'(-diff) : diff[ned_pkg::MAG_W-1:0];
    sq_d = ned_pkg::SQ_W'(mag) * ned_pkg::SQ_W'(mag);
  end

  // Hold the last pair while the queue has no room for its sum
  assign advance    = sq_valid_q && !(sq_last_q && full_i);
  assign in_stall_o = sq_valid_q && sq_last_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    sum_ext = {1'b0, acc_q} + (ned_pkg::SUM_W + 1)'(sq_q);
    sum_sat = (sum_ext >= {1'b0, ned_pkg::SUM_MAX}) ? ned_pkg::SUM_MAX
                                                   : sum_ext[ned_pkg::SUM_W-1:0];
    acc_d = acc_q;
    if (advance) begin
      acc_d = sq_last_q ? '0 : sum_sat;
    end
  end

  assign push_o     = advance && sq_last_q;
  assign push_sum_o = sum_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
      sq_last_q  <= 1'b0;
      acc_q      <= '0;
    end else begin
      acc_q <= acc_d;
      if (accept) begin
        sq_valid_q <= 1'b1;
        sq_last_q  <= in_data_i.last;
      end else if (advance) begin
        sq_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q <= sq_d;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("sum pushed into a full queue");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (acc_q == '0))
    else $error("sum not cleared after last pair");

endmodule

/* src/ned_queue.sv */
// ----------------------------------------------------------------------------
// ned_queue
// Two-entry queue of finished sums between the front and the back end.
// ----------------------------------------------------------------------------
module ned_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [ned_pkg::SUM_W-1:0] push_sum_i,
  output logic                      full_o,
  output ned_pkg::qout_t            head_o,
  input  logic                      pop_i
);

  logic [ned_pkg::SUM_W-1:0] mem_q [2];
  logic                      wr_ptr_q;
  logic                      rd_ptr_q;
  logic [1:0]                count_q;

  assign full_o       = (count_q == 2'd2);
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.sum   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_sum_i;
    end
  end

endmodule

/* src/ned_back.sv */
// ----------------------------------------------------------------------------
// ned_back
// Sequencer that turns one sum into a binding: maximum distance, a
// restoring fraction divide (one quotient bit a cycle) and a digit-by-digit
// square root (one result bit a cycle), or a clamp to 0 or 1.0, then the output register.
// ----------------------------------------------------------------------------
module ned_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ned_pkg::cfg_t  cfg_i,
  input  ned_pkg::qout_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ned_pkg::out_t  out_data_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SPAN  = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_MAXD  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_SQRT  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam int SPAN_W = ned_pkg::ELEMENT_BITS;
  localparam int ROOT_W = 32;
  localparam int PROD_W = ned_pkg::MAXD_W + ned_pkg::LEN_W;

  logic [2:0]                        state_q, state_d;
  logic [4:0]                        cnt_q, cnt_d;
  logic [ned_pkg::SUM_W-1:0]         sum_q, sum_d;
  logic [SPAN_W-1:0]                 span_q, span_d;
  logic [ned_pkg::SQ_W-1:0]          span2_q, span2_d;
  logic [ned_pkg::MAXD_W-1:0]        maxd_q, maxd_d;
  logic [ned_pkg::MAXD_W-1:0]        rem_q, rem_d;
  logic [31:0]                       quo_q, quo_d;
  logic [ROOT_W-1:0]                 op_q, op_d;
  logic [ROOT_W-1:0]                 res_q, res_d;
  logic [ROOT_W-1:0]                 one_q, one_d;
  logic [ned_pkg::BIND_W-1:0]        bind_q, bind_d;
  logic                              degen_q, degen_d;
  logic                              out_valid_q, out_valid_d;
  ned_pkg::out_t                     out_data_q, out_data_d;

  logic signed [SPAN_W:0]            span_diff;
  logic [ned_pkg::LEN_W-1:0]         len_cap;
  logic [ned_pkg::MAXD_W:0]          twice;
  logic [PROD_W-1:0]                 maxd_prod;
  logic [31:0]                       quo_next;
  logic [ROOT_W-1:0]                 trial;
  logic                              out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    span_diff = {cfg_i.upper_bound[SPAN_W-1], cfg_i.upper_bound}
              - {cfg_i.lower_bound[SPAN_W-1], cfg_i.lower_bound};
    len_cap   = (cfg_i.vector_length > ned_pkg::LEN_CAP) ? ned_pkg::LEN_CAP
                                                          : cfg_i.vector_length;
    maxd_prod = PROD_W'(span2_q) * PROD_W'(len_cap);
    twice     = {rem_q, 1'b0};
    quo_next  = {quo_q[30:0], (twice >= {1'b0, maxd_q})};
    trial     = res_q + one_q;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    span_d      = span_q;
    span2_d     = span2_q;
    maxd_d      = maxd_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    op_d        = op_q;
    res_d       = res_q;
    one_d       = one_q;
    bind_d      = bind_q;
    degen_d     = degen_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          sum_d   = head_i.sum;
          state_d = S_SPAN;
        end
      end
      S_SPAN: begin
        span_d  = span_diff[SPAN_W] ? SPAN_W'(-span_diff) : span_diff[SPAN_W-1:0];
        state_d = S_SQ;
      end
      S_SQ: begin
        span2_d = ned_pkg::SQ_W'(span_q) * ned_pkg::SQ_W'(span_q);
        state_d = S_MAXD;
      end
      S_MAXD: begin
        maxd_d  = maxd_prod[ned_pkg::MAXD_W-1:0];
        state_d = S_CHECK;
      end
      S_CHECK: begin
        degen_d = 1'b0;
        if (maxd_q == '0) begin
          degen_d = 1'b1;
          bind_d  = (sum_q != '0) ? ned_pkg::ONE_Q16 : '0;
          state_d = S_OUT;
        end else if (sum_q >= ned_pkg::SUM_W'(maxd_q)) begin
          bind_d  = ned_pkg::ONE_Q16;
          state_d = S_OUT;
        end else begin
          rem_d   = sum_q[ned_pkg::MAXD_W-1:0];
          quo_d   = '0;
          cnt_d   = 5'd31;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        quo_d = quo_next;
        rem_d = quo_next[0] ? ned_pkg::MAXD_W'(twice - {1'b0, maxd_q})
                            : twice[ned_pkg::MAXD_W-1:0];
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          op_d    = quo_next;
          res_d   = '0;
          one_d   = ROOT_W'(1) << (ROOT_W - 2);
          cnt_d   = 5'd15;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (op_q >= trial) begin
          op_d  = op_q - trial;
          res_d = (res_q >> 1) + one_q;
        end else begin
          res_d = res_q >> 1;
        end
        one_d = one_q >> 2;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          bind_d  = ned_pkg::BIND_W'(res_d);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // Wait for the output register to free up
        if (out_free) begin
          out_valid_d                 = 1'b1;
          out_data_d.binding          = bind_q;
          out_data_d.degenerate_range = degen_q;
          state_d                     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    span_q     <= span_d;
    span2_q    <= span2_d;
    maxd_q     <= maxd_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    op_q       <= op_d;
    res_q      <= res_d;
    one_q      <= one_d;
    bind_q     <= bind_d;
    degen_q    <= degen_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_div_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (maxd_q != '0) && (rem_q < maxd_q))
    else $error("divide remainder out of range");

  a_bind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.binding <= ned_pkg::ONE_Q16))
    else $error("binding above 1.0");

  a_degen_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate_range) |->
      (out_data_o.binding == '0) || (out_data_o.binding == ned_pkg::ONE_Q16))
    else $error("degenerate range with fractional binding");

endmodule

/* dv/ned_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ned_checker
// Watches the request, result and register ports of the normalized distance
// block. It keeps its own copy of the bounds, the length and the running sum,
// works out the expected binding for every request marked last, and compares
// each accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
module ned_checker
  import ned_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_t               in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_t              out_data_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  input  logic              pready_i,
  output int                errors_o,
  output int                pending_o
);

  logic signed [ELEMENT_BITS-1:0] lower_q;
  logic signed [ELEMENT_BITS-1:0] upper_q;
  logic [LEN_W-1:0]               length_q;
  logic [SUM_W-1:0]               sum_q;
  out_t                           bindings_q[$];
  int                             mismatch_count = 0;

  assign errors_o = mismatch_count;

  function automatic logic [MAG_W-1:0] distance(logic signed [ELEMENT_BITS-1:0] a,
                                                logic signed [ELEMENT_BITS-1:0] b);
    logic signed [ELEMENT_BITS:0] d;
    d = $signed({a[ELEMENT_BITS-1], a}) - $signed({b[ELEMENT_BITS-1], b});
    return d[ELEMENT_BITS] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  function automatic logic [SUM_W-1:0] add_square(logic [SUM_W-1:0] s, logic [MAG_W-1:0] m);
    logic [SQ_W-1:0] sq;
    sq = SQ_W'(m) * SQ_W'(m);
    // saturate instead of wrapping
    if (SUM_W'(sq) >= SUM_MAX - s) return SUM_MAX;
    return s + SUM_W'(sq);
  endfunction

  function automatic out_t close_vector(logic [SUM_W-1:0] s);
    out_t             res;
    logic [MAG_W-1:0] span;
    logic [LEN_W-1:0] len;
    logic [63:0]      max_dist;
    logic [127:0]     ratio;
    logic [31:0]      frac;
    logic [31:0]      trial;
    logic [15:0]      root;
    int               b;
    span     = distance(upper_q, lower_q);
    len      = (length_q > LEN_CAP) ? LEN_CAP : length_q;
    max_dist = 64'(span) * 64'(span) * 64'(len);
    res.degenerate_range = (max_dist == 64'd0);
    if (max_dist == 64'd0) begin
      res.binding = (s != '0) ? ONE_Q16 : '0;
    end else if (64'(s) >= max_dist) begin
      res.binding = ONE_Q16;
    end else begin
      // sqrt(sum / max) in Q0.16, truncated at both steps
      ratio = {52'b0, s, 32'b0} / {64'b0, max_dist};
      frac  = ratio[31:0];
      root  = '0;
      for (b = 15; b >= 0; b--) begin
        trial = {16'b0, root} | (32'd1 << b);
        if (64'(trial) * 64'(trial) <= 64'(frac)) root = trial[15:0];
      end
      res.binding = BIND_W'(root);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_t want;
    if (!rst_ni) begin
      lower_q  = LOWER_RESET;
      upper_q  = UPPER_RESET;
      length_q = LENGTH_RESET;
      sum_q    = '0;
      bindings_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (bindings_q.size() == 0) begin
          report_mismatch("result with no request outstanding", out_data_i.binding, 0);
        end else begin
          want = bindings_q.pop_front();
          if (out_data_i.binding !== want.binding)
            report_mismatch("binding", out_data_i.binding, want.binding);
          if (out_data_i.degenerate_range !== want.degenerate_range)
            report_mismatch("degenerate_range", out_data_i.degenerate_range,
                            want.degenerate_range);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ADDR_W-1:2])
          REG_LOWER:  lower_q  = pwdata_i[ELEMENT_BITS-1:0];
          REG_UPPER:  upper_q  = pwdata_i[ELEMENT_BITS-1:0];
          REG_LENGTH: length_q = pwdata_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        sum_q = add_square(sum_q, distance(in_data_i.other_element, in_data_i.own_element));
        if (in_data_i.last) begin
          bindings_q.push_back(close_vector(sum_q));
          sum_q = '0;
        end
      end
      pending_o <= bindings_q.size();
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives element pairs and register writes into the normalized distance
// block: directed vectors for the bounds, length and full-scale corners, then
// random vectors under several register settings with random gaps on both
// sides and one long result hold-off. The checker beside the block scores it.
// ----------------------------------------------------------------------------
module tb_top;
  import ned_pkg::*;

  localparam int LIMIT         = 400000;
  localparam int DRAIN         = 80;
  localparam int HOLD_CYCLES   = 700;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 190;
  localparam int LONG_ITEMS    = 150;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic signed [ELEMENT_BITS-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [ELEMENT_BITS-1:0] ELEM_MAX = 16'sh7fff;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                errors;
  int                pending;
  logic              quiet;
  logic              hold_req;
  int                cycle_count;

  normalized_euclidean_distance u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  ned_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stall before each result, one long hold-off on request
  initial begin : receiver
    int gap;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 3);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  task automatic send_pair(logic [ELEMENT_BITS-1:0] own, logic [ELEMENT_BITS-1:0] other,
                           logic last_pair);
    in_t pair;
    int  gap;
    pair.own_element   = own;
    pair.other_element = other;
    pair.last          = last_pair;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= pair;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  function automatic logic [ELEMENT_BITS-1:0] draw_element();
    if ($urandom_range(0, 7) == 0) return ELEMENT_BITS'($urandom);
    return ELEMENT_BITS'($urandom_range(0, 4095) - 2048);
  endfunction

  task automatic send_vector(int n);
    int i;
    for (i = 0; i < n; i++) send_pair(draw_element(), draw_element(), i == n - 1);
  endtask

  // Drop valid, wait for every result, then let the back end settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_config(logic [ELEMENT_BITS-1:0] lo, logic [ELEMENT_BITS-1:0] hi,
                            logic [LEN_W-1:0] len, bit poke_spare);
    wait_idle();
    write_reg(REG_LOWER, {16'($urandom), lo});
    write_reg(REG_UPPER, {16'($urandom), hi});
    write_reg(REG_LENGTH, {21'($urandom), len});
    if (poke_spare) write_reg(REG_SPARE, $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int i;
    int p;
    int sent;
    int n;
    logic [ELEMENT_BITS-1:0] lo;
    logic [ELEMENT_BITS-1:0] hi;
    logic [LEN_W-1:0]        len;

    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    quiet    <= 1'b0;
    hold_req <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: span 256, length one
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sd256, 1'b1);
    send_pair(16'sd0, 16'sd128, 1'b1);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    send_pair(ELEM_MAX, ELEM_MIN, 1'b1);
    send_pair(16'sd10, -16'sd10, 1'b0);
    send_pair(-16'sd1, 16'sd1, 1'b1);

    // widest span and full length; a long vector of full-scale differences
    set_config(ELEM_MIN, ELEM_MAX, LEN_W'(1024), 1'b0);
    send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(16'sd100, -16'sd100, 1'b1);
    for (i = 0; i < LONG_ITEMS; i++) send_pair(ELEM_MIN, ELEM_MAX, i == LONG_ITEMS - 1);

    // reversed bounds, length above the cap
    set_config(16'sd300, -16'sd200, LEN_W'(2047), 1'b0);
    send_vector(3);
    send_pair(16'sd300, -16'sd200, 1'b1);

    // zero span
    set_config(-16'sd512, -16'sd512, LEN_W'(3), 1'b0);
    send_pair(16'sd5, 16'sd5, 1'b1);
    send_pair(16'sd0, 16'sd1, 1'b1);

    // zero length, plus a write to the unmapped slot
    set_config(-16'sd256, 16'sd256, LEN_W'(0), 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd1, 16'sd2, 1'b1);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      lo = ($urandom_range(0, 3) == 0) ? ELEMENT_BITS'($urandom)
                                       : ELEMENT_BITS'(-$urandom_range(0, 2048));
      hi = ($urandom_range(0, 3) == 0) ? ELEMENT_BITS'($urandom)
                                       : ELEMENT_BITS'($urandom_range(0, 2048));
      if (p == 3) begin
        lo = ELEM_MAX;
        hi = ELEM_MIN;
      end
      len = ($urandom_range(0, 5) == 0) ? LEN_W'($urandom_range(0, 2047))
                                        : LEN_W'($urandom_range(1, 10));
      set_config(lo, hi, len, 1'b0);
      quiet <= (p == 2);
      if (p == 0) hold_req <= 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_vector(n);
        sent += n;
      end
    end

    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
